// File: rtl/core/boh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Object heap package
// Opcodes, status codes, field widths and default sizes for the object heap.
// ----------------------------------------------------------------------------
package boh_pkg;

    localparam int OBJECT_SLOTS_DEF = 1024;
    localparam int FIELD_WORDS_DEF  = 4096;

    localparam int OPCODE_W = 3;
    localparam int REF_W    = 10;
    localparam int INDEX_W  = 12;
    localparam int VALUE_W  = 32;
    localparam int CLASS_W  = 16;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 3;

    // width of the shared adder: holds any heap size plus any field count
    localparam int CALC_W = 18;

    localparam logic [OPCODE_W-1:0] OP_ALLOC  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_CLASS  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_REINIT = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_STORAGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_REF       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_BOUNDS = 3'd4;

endpackage
`default_nettype wire

// File: rtl/core/boh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Object heap RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module boh_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/bump_object_heap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bump-pointer object heap
// Allocate, field read/write, class query and reinitialise under one sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// the result ports for one cycle with done high, and must be taken then, as
// there is no way to hold it off. Reinitialise, unused opcodes and failed
// allocations finish from the idle state; class queries, writes and failed
// accesses after the object table read; reads after the object table read and
// then the field store read; and a successful allocation after its field
// words are cleared one per cycle through the field store's single
// write port. Both stores are used without any clearing pass after reset.
module bump_object_heap
    import boh_pkg::*;
#(
    parameter int OBJECT_SLOTS = OBJECT_SLOTS_DEF,
    parameter int FIELD_WORDS  = FIELD_WORDS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic        [OPCODE_W-1:0] opcode,
    input  wire logic        [REF_W-1:0]    object_ref,
    input  wire logic        [INDEX_W-1:0]  word_index,
    input  wire logic signed [VALUE_W-1:0]  write_value,
    input  wire logic        [CLASS_W-1:0]  class_id,
    input  wire logic        [COUNT_W-1:0]  field_count,
    output logic                            done,
    output logic             [STATUS_W-1:0] status,
    output logic             [REF_W-1:0]    new_ref,
    output logic signed      [VALUE_W-1:0]  read_value,
    output logic             [CLASS_W-1:0]  class_out,
    output logic                            class_valid
);

    localparam int OBJ_W  = $clog2(OBJECT_SLOTS);
    localparam int NOBJ_W = $clog2(OBJECT_SLOTS + 1);
    localparam int FW_W   = (FIELD_WORDS > 1) ? $clog2(FIELD_WORDS) : 1;
    localparam int NW_W   = $clog2(FIELD_WORDS + 1);
    localparam int ENT_W  = CLASS_W + 2 * NW_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_ACCESS,
        S_ZERO
    } state_t;

    state_t               state_reg, state_next;
    logic [OPCODE_W-1:0]  op_reg, op_next;
    logic [REF_W-1:0]     ref_reg, ref_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [VALUE_W-1:0]   wval_reg, wval_next;
    logic [NOBJ_W-1:0]    next_object_reg, next_object_next;
    logic [NW_W-1:0]      next_word_reg, next_word_next;
    logic [NW_W-1:0]      zcnt_reg, zcnt_next;
    logic [FW_W-1:0]      zaddr_reg, zaddr_next;
    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [REF_W-1:0]     new_ref_reg, new_ref_next;
    logic [VALUE_W-1:0]   read_value_reg, read_value_next;
    logic [CLASS_W-1:0]   class_out_reg, class_out_next;
    logic                 class_valid_reg, class_valid_next;

    // shared adder
    logic [CALC_W-1:0]    add_a, add_b, add_sum;

    logic                 tbl_we, tbl_re;
    logic [OBJ_W-1:0]     tbl_waddr, tbl_raddr;
    logic [ENT_W-1:0]     tbl_wdata, tbl_rdata;
    logic                 fld_we, fld_re;
    logic [FW_W-1:0]      fld_waddr, fld_raddr;
    logic [VALUE_W-1:0]   fld_wdata, fld_rdata;

    logic [CLASS_W-1:0]   ent_class;
    logic [NW_W-1:0]      ent_base, ent_count;
    logic [CALC_W-1:0]    ref_wide, in_ref_wide;
    logic                 ref_live, idx_ok;

    assign add_sum     = add_a + add_b;
    assign ent_count   = tbl_rdata[NW_W-1:0];
    assign ent_base    = tbl_rdata[2*NW_W-1:NW_W];
    assign ent_class   = tbl_rdata[ENT_W-1:2*NW_W];
    assign ref_wide    = CALC_W'(ref_reg);
    assign in_ref_wide = CALC_W'(object_ref);
    assign ref_live    = (ref_wide != '0) && (ref_wide < CALC_W'(next_object_reg))
                         && (ref_wide < CALC_W'(OBJECT_SLOTS));
    assign idx_ok      = CALC_W'(idx_reg) < CALC_W'(ent_count);

    boh_ram #(
        .DEPTH (OBJECT_SLOTS),
        .WIDTH (ENT_W),
        .ADDR_W(OBJ_W)
    ) u_object_table (
        .clk  (clk),
        .we   (tbl_we),
        .waddr(tbl_waddr),
        .wdata(tbl_wdata),
        .re   (tbl_re),
        .raddr(tbl_raddr),
        .rdata(tbl_rdata)
    );

    boh_ram #(
        .DEPTH (FIELD_WORDS),
        .WIDTH (VALUE_W),
        .ADDR_W(FW_W)
    ) u_field_store (
        .clk  (clk),
        .we   (fld_we),
        .waddr(fld_waddr),
        .wdata(fld_wdata),
        .re   (fld_re),
        .raddr(fld_raddr),
        .rdata(fld_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        ref_next         = ref_reg;
        idx_next         = idx_reg;
        wval_next        = wval_reg;
        next_object_next = next_object_reg;
        next_word_next   = next_word_reg;
        zcnt_next        = zcnt_reg;
        zaddr_next       = zaddr_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        new_ref_next     = new_ref_reg;
        read_value_next  = read_value_reg;
        class_out_next   = class_out_reg;
        class_valid_next = class_valid_reg;

        add_a     = '0;
        add_b     = '0;
        tbl_we    = 1'b0;
        tbl_waddr = next_object_reg[OBJ_W-1:0];
        tbl_wdata = {class_id, next_word_reg, NW_W'(field_count)};
        tbl_re    = 1'b0;
        tbl_raddr = in_ref_wide[OBJ_W-1:0];
        fld_we    = 1'b0;
        fld_waddr = zaddr_reg;
        fld_wdata = '0;
        fld_re    = 1'b0;
        fld_raddr = add_sum[FW_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                add_a = CALC_W'(next_word_reg);
                add_b = CALC_W'(field_count);
                if (start)
                begin
                    op_next          = opcode;
                    ref_next         = object_ref;
                    idx_next         = word_index;
                    wval_next        = write_value;
                    status_next      = ST_OK;
                    new_ref_next     = '0;
                    read_value_next  = '0;
                    class_out_next   = '0;
                    class_valid_next = 1'b0;
                    unique case (opcode) inside
                        OP_ALLOC:
                        begin
                            if (CALC_W'(next_object_reg) >= CALC_W'(OBJECT_SLOTS))
                            begin
                                status_next = ST_NO_SLOT;
                                done_next   = 1'b1;
                            end
                            else if (add_sum > CALC_W'(FIELD_WORDS))
                            begin
                                status_next = ST_NO_STORAGE;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                tbl_we           = 1'b1;
                                next_object_next = next_object_reg + 1'b1;
                                next_word_next   = add_sum[NW_W-1:0];
                                new_ref_next     = REF_W'(next_object_reg);
                                if (field_count == '0)
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    zcnt_next  = NW_W'(field_count);
                                    zaddr_next = next_word_reg[FW_W-1:0];
                                    state_next = S_ZERO;
                                end
                            end
                        end
                        OP_READ, OP_WRITE, OP_CLASS:
                        begin
                            tbl_re     = 1'b1;
                            state_next = S_LOOKUP;
                        end
                        OP_REINIT:
                        begin
                            next_object_next = NOBJ_W'(1);
                            next_word_next   = '0;
                            done_next        = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_LOOKUP:
            begin
                add_a      = CALC_W'(ent_base);
                add_b      = CALC_W'(idx_reg);
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (!ref_live)
                begin
                    status_next = ST_BAD_REF;
                end
                else if (op_reg == OP_CLASS)
                begin
                    class_out_next   = ent_class;
                    class_valid_next = 1'b1;
                end
                else if (!idx_ok)
                begin
                    status_next = ST_OUT_OF_BOUNDS;
                end
                else if (op_reg == OP_READ)
                begin
                    fld_re     = 1'b1;
                    state_next = S_ACCESS;
                    done_next  = 1'b0;
                end
                else
                begin
                    fld_we    = 1'b1;
                    fld_waddr = add_sum[FW_W-1:0];
                    fld_wdata = wval_reg;
                end
            end
            S_ACCESS:
            begin
                read_value_next = fld_rdata;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            S_ZERO:
            begin
                // clear one field word per cycle
                fld_we     = 1'b1;
                add_a      = CALC_W'(zaddr_reg);
                add_b      = CALC_W'(1);
                zaddr_next = add_sum[FW_W-1:0];
                zcnt_next  = zcnt_reg - 1'b1;
                if (zcnt_reg == NW_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= '0;
            ref_reg         <= '0;
            idx_reg         <= '0;
            wval_reg        <= '0;
            next_object_reg <= NOBJ_W'(1);
            next_word_reg   <= '0;
            zcnt_reg        <= '0;
            zaddr_reg       <= '0;
            done_reg        <= 1'b0;
            status_reg      <= '0;
            new_ref_reg     <= '0;
            read_value_reg  <= '0;
            class_out_reg   <= '0;
            class_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            ref_reg         <= ref_next;
            idx_reg         <= idx_next;
            wval_reg        <= wval_next;
            next_object_reg <= next_object_next;
            next_word_reg   <= next_word_next;
            zcnt_reg        <= zcnt_next;
            zaddr_reg       <= zaddr_next;
            done_reg        <= done_next;
            status_reg      <= status_next;
            new_ref_reg     <= new_ref_next;
            read_value_reg  <= read_value_next;
            class_out_reg   <= class_out_next;
            class_valid_reg <= class_valid_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign new_ref     = new_ref_reg;
    assign read_value  = read_value_reg;
    assign class_out   = class_out_reg;
    assign class_valid = class_valid_reg;

`ifndef SYNTHESIS
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted item neither in progress nor finished");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> read_value == '0 && new_ref == '0 && !class_valid)
        else $error("failed item carries data");

    a_heap_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        next_word_reg <= NW_W'(FIELD_WORDS) && next_object_reg != '0)
        else $error("heap pointers out of range");

    a_zero_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ZERO |-> zcnt_reg != '0)
        else $error("clearing sweep with nothing left to clear");
`endif

endmodule
`default_nettype wire

// File: bench/bump_object_heap_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Object heap testbench
// Drives a directed table and then random requests through the start/busy
// handshake, takes each expected result from the table row or else from a model
// of the heap kept here, and compares each done strobe with the oldest one outstanding.
// ----------------------------------------------------------------------------
module bump_object_heap_tb
    import boh_pkg::*;
;

    localparam int SLOTS        = OBJECT_SLOTS_DEF;
    localparam int WORDS        = FIELD_WORDS_DEF;
    localparam int RANDOM_ITEMS = 2000;
    localparam int FLOOD_FIRST  = 300;
    localparam int FLOOD_LAST   = 1600;
    localparam int QUIET_FIRST  = 1700;
    localparam int QUIET_LAST   = 1950;
    localparam int STALL_LIMIT  = 20000;

    localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic        [OPCODE_W-1:0] opcode;
        logic        [REF_W-1:0]    object_ref;
        logic        [INDEX_W-1:0]  word_index;
        logic signed [VALUE_W-1:0]  write_value;
        logic        [CLASS_W-1:0]  class_id;
        logic        [COUNT_W-1:0]  field_count;
    } heap_req_t;

    typedef struct packed {
        logic        [STATUS_W-1:0] status;
        logic        [REF_W-1:0]    new_ref;
        logic signed [VALUE_W-1:0]  read_value;
        logic        [CLASS_W-1:0]  class_out;
        logic                       class_valid;
    } heap_resp_t;

    typedef struct {
        heap_req_t  req;
        bit         fixed;
        heap_resp_t resp;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic        [OPCODE_W-1:0] opcode = '0;
    logic        [REF_W-1:0]    object_ref = '0;
    logic        [INDEX_W-1:0]  word_index = '0;
    logic signed [VALUE_W-1:0]  write_value = '0;
    logic        [CLASS_W-1:0]  class_id = '0;
    logic        [COUNT_W-1:0]  field_count = '0;
    logic                       done;
    logic        [STATUS_W-1:0] status;
    logic        [REF_W-1:0]    new_ref;
    logic signed [VALUE_W-1:0]  read_value;
    logic        [CLASS_W-1:0]  class_out;
    logic                       class_valid;

    // heap model
    int unsigned        obj_cursor = 1;
    int unsigned        next_wd = 0;
    logic [CLASS_W-1:0] obj_cls [SLOTS];
    int unsigned        obj_base [SLOTS];
    int unsigned        obj_len [SLOTS];
    logic [VALUE_W-1:0] heap_words [WORDS];

    heap_resp_t pending_results[$];
    int         mismatches = 0;
    int         stall_cycles = 0;

    bump_object_heap dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .object_ref  (object_ref),
        .word_index  (word_index),
        .write_value (write_value),
        .class_id    (class_id),
        .field_count (field_count),
        .done        (done),
        .status      (status),
        .new_ref     (new_ref),
        .read_value  (read_value),
        .class_out   (class_out),
        .class_valid (class_valid)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit ref_live(logic [REF_W-1:0] r);
        return r != 0 && r < obj_cursor;
    endfunction

    function automatic heap_resp_t heap_apply(heap_req_t q);
        heap_resp_t  r;
        int unsigned a;
        r = '0;
        case (q.opcode) inside
            OP_ALLOC:
            begin
                if (obj_cursor >= SLOTS)
                    r.status = ST_NO_SLOT;
                else if (next_wd + q.field_count > WORDS)
                    r.status = ST_NO_STORAGE;
                else
                begin
                    r.new_ref = REF_W'(obj_cursor);
                    obj_cls[obj_cursor]  = q.class_id;
                    obj_base[obj_cursor] = next_wd;
                    obj_len[obj_cursor]  = q.field_count;
                    for (a = 0; a < q.field_count; a++)
                        heap_words[next_wd + a] = '0;
                    obj_cursor++;
                    next_wd += q.field_count;
                end
            end
            OP_READ, OP_WRITE:
            begin
                if (!ref_live(q.object_ref))
                    r.status = ST_BAD_REF;
                else if (q.word_index >= obj_len[q.object_ref])
                    r.status = ST_OUT_OF_BOUNDS;
                else
                begin
                    a = obj_base[q.object_ref] + q.word_index;
                    if (q.opcode == OP_READ)
                        r.read_value = heap_words[a];
                    else
                        heap_words[a] = q.write_value;
                end
            end
            OP_CLASS:
            begin
                if (!ref_live(q.object_ref))
                    r.status = ST_BAD_REF;
                else
                begin
                    r.class_out   = obj_cls[q.object_ref];
                    r.class_valid = 1'b1;
                end
            end
            // stale table entries are never reached: liveness goes by obj_cursor
            // and allocation clears its words
            OP_REINIT:
            begin
                obj_cursor = 1;
                next_wd    = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic heap_req_t ask(logic [OPCODE_W-1:0] op, int r, int idx, int wval,
                                      int cls, int cnt);
        heap_req_t q;
        q.opcode      = op;
        q.object_ref  = REF_W'(r);
        q.word_index  = INDEX_W'(idx);
        q.write_value = wval;
        q.class_id    = CLASS_W'(cls);
        q.field_count = COUNT_W'(cnt);
        return q;
    endfunction

    function automatic heap_resp_t outcome(logic [STATUS_W-1:0] st, int nref, int rval,
                                           int cout, bit cv);
        heap_resp_t r;
        r.status      = st;
        r.new_ref     = REF_W'(nref);
        r.read_value  = rval;
        r.class_out   = CLASS_W'(cout);
        r.class_valid = cv;
        return r;
    endfunction

    // random request; mostly well-formed accesses to live objects
    function automatic heap_req_t make_req(bit flood);
        heap_req_t q;
        int        p;
        q.opcode      = OP_ALLOC;
        q.object_ref  = REF_W'($urandom_range(0, SLOTS - 1));
        q.word_index  = INDEX_W'($urandom);
        q.write_value = $urandom;
        q.class_id    = CLASS_W'($urandom);
        p = $urandom_range(0, 99);
        if (flood)
            q.field_count = COUNT_W'($urandom_range(0, 2));
        else if (p < 85)
            q.field_count = COUNT_W'($urandom_range(0, 8));
        else if (p < 97)
            q.field_count = COUNT_W'($urandom_range(9, 64));
        else
            q.field_count = COUNT_W'($urandom_range(65, WORDS));

        p = $urandom_range(0, 99);
        if (flood)
        begin
            if (p < 88)
                q.opcode = OP_ALLOC;
            else if (p < 92)
                q.opcode = OP_READ;
            else if (p < 95)
                q.opcode = OP_WRITE;
            else if (p < 98)
                q.opcode = OP_CLASS;
            else
                q.opcode = OPCODE_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
        end
        else
        begin
            if (p < 35)
                q.opcode = OP_ALLOC;
            else if (p < 60)
                q.opcode = OP_READ;
            else if (p < 82)
                q.opcode = OP_WRITE;
            else if (p < 92)
                q.opcode = OP_CLASS;
            else if (p < 96)
                q.opcode = OP_REINIT;
            else
                q.opcode = OPCODE_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
        end

        p = $urandom_range(0, 99);
        if (obj_cursor > 1 && p < 85)
            q.object_ref = REF_W'($urandom_range(1, obj_cursor - 1));
        else if (p < 92)
            q.object_ref = '0;
        if (ref_live(q.object_ref) && obj_len[q.object_ref] > 0 && $urandom_range(0, 99) < 85)
            q.word_index = INDEX_W'($urandom_range(0, obj_len[q.object_ref] - 1));
        return q;
    endfunction

    task automatic send(heap_req_t q, bit fixed, heap_resp_t want);
        heap_resp_t predicted;
        @(negedge clk);
        start       <= 1'b1;
        opcode      <= q.opcode;
        object_ref  <= q.object_ref;
        word_index  <= q.word_index;
        write_value <= q.write_value;
        class_id    <= q.class_id;
        field_count <= q.field_count;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = heap_apply(q);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 99) < 10)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 4))
                @(negedge clk);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        heap_resp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing outstanding: status %0d", status);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, status);
                check_field("new_ref", want.new_ref, new_ref);
                check_field("read_value", want.read_value, read_value);
                check_field("class_out", want.class_out, class_out);
                check_field("class_valid", want.class_valid, class_valid);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        heap_req_t q;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        rows.push_back('{ask(OP_READ, 0, 0, 0, 0, 0), 1'b1, outcome(ST_BAD_REF, 0, 0, 0, 0)});
        rows.push_back('{ask(OP_CLASS, 1, 0, 0, 0, 0), 1'b1, outcome(ST_BAD_REF, 0, 0, 0, 0)});
        // zero-sized object: allocates, but no field can be touched
        rows.push_back('{ask(OP_ALLOC, 0, 0, 0, 'hFFFF, 0), 1'b1, outcome(ST_OK, 1, 0, 0, 0)});
        rows.push_back('{ask(OP_READ, 1, 0, 0, 0, 0), 1'b1,
                         outcome(ST_OUT_OF_BOUNDS, 0, 0, 0, 0)});
        rows.push_back('{ask(OP_WRITE, 1, 0, 'h1234, 0, 0), 1'b1,
                         outcome(ST_OUT_OF_BOUNDS, 0, 0, 0, 0)});
        rows.push_back('{ask(OP_CLASS, 1, 0, 0, 0, 0), 1'b1, outcome(ST_OK, 0, 0, 'hFFFF, 1)});
        rows.push_back('{ask(OP_ALLOC, 0, 0, 0, 0, 4), 1'b1, outcome(ST_OK, 2, 0, 0, 0)});
        rows.push_back('{ask(OP_WRITE, 2, 3, 'h8000_0000, 0, 0), 1'b0, '0});
        rows.push_back('{ask(OP_WRITE, 2, 0, 'h7FFF_FFFF, 0, 0), 1'b0, '0});
        rows.push_back('{ask(OP_READ, 2, 3, 0, 0, 0), 1'b0, '0});
        rows.push_back('{ask(OP_READ, 2, 0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{ask(OP_READ, 2, 1, 0, 0, 0), 1'b0, '0});
        rows.push_back('{ask(OP_READ, 2, 4, 0, 0, 0), 1'b1,
                         outcome(ST_OUT_OF_BOUNDS, 0, 0, 0, 0)});
        rows.push_back('{ask(OP_WRITE, 1023, 0, -1, 0, 0), 1'b1,
                         outcome(ST_BAD_REF, 0, 0, 0, 0)});
        // fills the field store exactly, then one more word must fail
        rows.push_back('{ask(OP_ALLOC, 0, 0, 0, 'h5A5A, 4092), 1'b1,
                         outcome(ST_OK, 3, 0, 0, 0)});
        rows.push_back('{ask(OP_ALLOC, 0, 0, 0, 0, 1), 1'b1,
                         outcome(ST_NO_STORAGE, 0, 0, 0, 0)});
        rows.push_back('{ask(OP_ALLOC, 0, 0, 0, 0, 0), 1'b1, outcome(ST_OK, 4, 0, 0, 0)});
        rows.push_back('{ask(OP_WRITE, 3, 4091, -1, 0, 0), 1'b0, '0});
        rows.push_back('{ask(OP_READ, 3, 4091, 0, 0, 0), 1'b0, '0});
        rows.push_back('{ask(OP_READ, 3, 4095, 0, 0, 0), 1'b1,
                         outcome(ST_OUT_OF_BOUNDS, 0, 0, 0, 0)});
        rows.push_back('{ask(OP_SPARE_5, 1023, 4095, -1, 'hFFFF, 4096), 1'b1,
                         outcome(ST_OK, 0, 0, 0, 0)});
        rows.push_back('{ask(OP_SPARE_6, 2, 0, -1, 'hFFFF, 4096), 1'b1,
                         outcome(ST_OK, 0, 0, 0, 0)});
        rows.push_back('{ask(OP_SPARE_7, 1, 0, 1, 1, 1), 1'b1, outcome(ST_OK, 0, 0, 0, 0)});
        rows.push_back('{ask(OP_REINIT, 0, 0, 0, 0, 0), 1'b1, outcome(ST_OK, 0, 0, 0, 0)});
        rows.push_back('{ask(OP_CLASS, 2, 0, 0, 0, 0), 1'b1, outcome(ST_BAD_REF, 0, 0, 0, 0)});
        rows.push_back('{ask(OP_ALLOC, 0, 0, 0, 'h8001, 4096), 1'b1,
                         outcome(ST_OK, 1, 0, 0, 0)});
        rows.push_back('{ask(OP_READ, 1, 4095, 0, 0, 0), 1'b0, '0});

        foreach (rows[i])
        begin
            maybe_idle();
            send(rows[i].req, rows[i].fixed, rows[i].resp);
        end

        // flood window: opens with a reinitialise, then allocation-heavy with no other, to run out of slots
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            q = make_req(i >= FLOOD_FIRST && i < FLOOD_LAST);
            if (i == FLOOD_FIRST)
                q.opcode = OP_REINIT;
            if (i < QUIET_FIRST || i >= QUIET_LAST)
                maybe_idle();
            send(q, 1'b0, '0);
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/boh_pkg.sv
rtl/core/boh_ram.sv
rtl/core/bump_object_heap.sv
bench/bump_object_heap_tb.sv
